/* hdl/lphs_pkg.sv */
// Package for the linear-probing hash set unit.
// Holds slot mark codes, request mode codes, status codes and the key and hash widths. No dependencies.
package lphs_pkg;
  typedef logic [1:0] mark_t;
  localparam mark_t MARK_EMPTY   = 2'd0;
  localparam mark_t MARK_FILLED  = 2'd1;
  localparam mark_t MARK_DELETED = 2'd2;

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;

  localparam logic [1:0] STAT_DONE = 2'd0;
  localparam logic [1:0] STAT_NOOP = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  localparam int KEY_W  = 64;
  localparam int HASH_W = 32;
endpackage

/* hdl/linear_probe_hash_set_unit.sv */
// Top level of the linear-probing hash set unit: sequencer, slot stores, result register.
// Depends on lphs_pkg.
//
// channel | direction | signals
// in      | input     | in_valid, in_ready, in_mode, in_key
// out     | output    | out_valid, out_ready, out_found, out_slot, out_status, out_element_total
// cfg     | input     | cfg_valid, cfg_ready, cfg_data
//
// An item is hashed over its key characters, then reduced to a remainder by shift-subtract,
// then each probed slot is read from memory and compared, and finally the result is
// committed and loaded into the result register.
// The shift-subtract unit sets the modulo time; the single memory read port
// sets the probe time. After reset a clearing pass writes TABLE_SIZE mark entries,
// one a cycle, before the first item is taken. A stalled result holds in the output
// register and blocks the next item only until it is taken.
module linear_probe_hash_set_unit #(
  parameter int TABLE_SIZE = 256,
  parameter int KEY_CHARS  = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [63:0] in_key,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_found,
  output logic [7:0]  out_slot,
  output logic [1:0]  out_status,
  output logic [8:0]  out_element_total,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data
);
  import lphs_pkg::*;

  localparam int AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int LW = AW + 1;        // holds TABLE_SIZE itself
  localparam int CW = $clog2(KEY_CHARS + 1);

  localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_HASH = 4'd2, S_MOD = 4'd3,
                         S_READ = 4'd4, S_CMP = 4'd5, S_DONE = 4'd6, S_OUT = 4'd7;

  // Slot stores; marks are cleared by the pass after reset, keys never.
  mark_t             marks_mem [TABLE_SIZE];
  logic [KEY_W-1:0]  keys_mem  [TABLE_SIZE];

  logic [3:0]        state_r, state_nxt;
  logic [8:0]        tlen_r;
  logic [LW-1:0]     len_r;           // effective length, latched per item
  logic [1:0]        mode_r;
  logic [KEY_W-1:0]  raw_r, key_r;
  logic [HASH_W-1:0] hash_r;
  logic [CW-1:0]     chr_r;
  logic              ended_r;
  logic [HASH_W-1:0] rem_r;           // remainder during modulo
  logic [5:0]        bit_r;
  logic [AW-1:0]     idx_r;
  logic [LW-1:0]     step_r;
  logic              del_seen_r;
  logic [AW-1:0]     del_idx_r;
  logic [8:0]        count_r;
  logic [AW-1:0]     clr_r;
  mark_t             rd_mark_r;
  logic [KEY_W-1:0]  rd_key_r;
  logic              hit_r, place_ok_r;
  logic [AW-1:0]     pos_r;
  logic              ov_r, of_r;
  logic [7:0]        os_r;
  logic [1:0]        ost_r;
  logic [8:0]        oc_r;

  // Effective length from the register.
  logic [LW-1:0] eff_len;
  always_comb begin
    if (tlen_r == 9'd0) eff_len = LW'(1);
    else if ({1'b0, tlen_r} > 10'(TABLE_SIZE)) eff_len = LW'(TABLE_SIZE);
    else eff_len = LW'(tlen_r);
  end

  // Current character, taken from the top byte of the shifting raw key.
  logic [6:0] chr;
  assign chr = raw_r[62:56];

  // One shift-subtract step of the modulo.
  logic [HASH_W:0] trial;
  assign trial = {rem_r, hash_r[31]} - (HASH_W+1)'(len_r);

  logic [AW-1:0] idx_inc;
  assign idx_inc = (32'(idx_r) + 32'd1 >= 32'(len_r)) ? '0 : idx_r + AW'(1);

  assign in_ready  = (state_r == S_IDLE) && !ov_r;
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (32'(clr_r) == TABLE_SIZE - 1) state_nxt = S_IDLE;
      S_IDLE:  if (in_valid && in_ready) state_nxt = S_HASH;
      S_HASH:  if (32'(chr_r) == KEY_CHARS - 1) state_nxt = S_MOD;
      S_MOD:   if (bit_r == 6'd31) state_nxt = S_READ;
      S_READ:  state_nxt = S_CMP;
      S_CMP: begin
        if (rd_mark_r == MARK_EMPTY ||
            (rd_mark_r == MARK_FILLED && rd_key_r == key_r) ||
            step_r + LW'(1) >= len_r) state_nxt = S_DONE;
        else state_nxt = S_READ;
      end
      S_DONE:  state_nxt = S_OUT;
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      tlen_r  <= 9'd256;
      count_r <= '0;
      clr_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) tlen_r <= cfg_data;
      if (out_valid && out_ready) ov_r <= 1'b0;
      case (state_r)
        S_CLEAR: clr_r <= clr_r + AW'(1);
        S_DONE: begin
          if (mode_r == MODE_ADD && !hit_r && place_ok_r && 32'(count_r) < 32'(len_r))
            count_r <= count_r + 9'd1;
          else if (mode_r == MODE_REMOVE && hit_r && count_r != 9'd0)
            count_r <= count_r - 9'd1;
        end
        S_OUT: ov_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // Datapath and memories.
  always_ff @(posedge clk) begin
    if (state_r == S_CLEAR) marks_mem[clr_r] <= MARK_EMPTY;
    case (state_r)
      S_IDLE: begin
        mode_r  <= in_mode;
        raw_r   <= {1'b0, in_key[62:0]};
        key_r   <= '0;
        hash_r  <= '0;
        chr_r   <= '0;
        ended_r <= 1'b0;
        len_r   <= eff_len;
      end
      S_HASH: begin
        if (!ended_r && chr != 7'd0) begin
          key_r  <= key_r | ({57'd0, chr} << (56 - 8 * int'(chr_r)));
          hash_r <= (hash_r << 5) - hash_r + HASH_W'(chr);
        end else begin
          ended_r <= 1'b1;
        end
        raw_r <= {1'b0, raw_r[54:0], 8'd0};
        chr_r <= chr_r + CW'(1);
        rem_r <= '0;
        bit_r <= '0;
      end
      S_MOD: begin
        if (!trial[HASH_W]) rem_r <= trial[HASH_W-1:0];
        else rem_r <= {rem_r[HASH_W-2:0], hash_r[31]};
        hash_r <= {hash_r[30:0], 1'b0};
        bit_r  <= bit_r + 6'd1;
        if (bit_r == 6'd31) begin
          idx_r <= (!trial[HASH_W]) ? AW'(trial[HASH_W-1:0])
                                    : AW'({rem_r[HASH_W-2:0], hash_r[31]});
        end
        step_r     <= '0;
        del_seen_r <= 1'b0;
        del_idx_r  <= '0;
      end
      S_READ: begin
        rd_mark_r <= marks_mem[idx_r];
        rd_key_r  <= keys_mem[idx_r];
      end
      S_CMP: begin
        hit_r      <= 1'b0;
        place_ok_r <= 1'b0;
        if (rd_mark_r == MARK_EMPTY) begin
          place_ok_r <= 1'b1;
          pos_r      <= del_seen_r ? del_idx_r : idx_r;
        end else if (rd_mark_r == MARK_FILLED && rd_key_r == key_r) begin
          hit_r <= 1'b1;
          pos_r <= idx_r;
        end else begin
          if (rd_mark_r == MARK_DELETED && !del_seen_r) begin
            del_seen_r <= 1'b1;
            del_idx_r  <= idx_r;
          end
          if (step_r + LW'(1) >= len_r) begin
            place_ok_r <= del_seen_r || rd_mark_r == MARK_DELETED;
            pos_r      <= del_seen_r ? del_idx_r : idx_r;
          end
        end
        idx_r  <= idx_inc;
        step_r <= step_r + LW'(1);
      end
      S_DONE: begin
        of_r  <= hit_r;
        os_r  <= '0;
        ost_r <= STAT_NOOP;
        if (mode_r == MODE_ADD) begin
          if (hit_r) begin
            os_r <= 8'(pos_r);
          end else if (32'(count_r) >= 32'(len_r) || !place_ok_r) begin
            ost_r <= STAT_FULL;
          end else begin
            os_r  <= 8'(pos_r);
            ost_r <= STAT_DONE;
            keys_mem[pos_r]  <= key_r;
            marks_mem[pos_r] <= MARK_FILLED;
          end
        end else if (hit_r) begin
          os_r  <= 8'(pos_r);
          ost_r <= STAT_DONE;
          if (mode_r == MODE_REMOVE) marks_mem[pos_r] <= MARK_DELETED;
        end
      end
      default: ;
    endcase
    if (state_r == S_OUT) oc_r <= count_r;
  end

  assign out_valid         = ov_r;
  assign out_found         = of_r;
  assign out_slot          = os_r;
  assign out_status        = ost_r;
  assign out_element_total = oc_r;

`ifndef NO_ASSERTIONS
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready) else $error("ready while busy");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= TABLE_SIZE) else $error("count over table size");
  a_out_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == S_OUT) else $error("result without item");
`endif
endmodule
